@@ design/bmh64_pkg.sv @@
// ----------------------------------------------------------------------------
// bmh64_pkg
// Shared types and constants for the 64-bit block mix hash.
// ----------------------------------------------------------------------------
package bmh64_pkg;

  localparam logic [63:0] HC1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] HC2    = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] HGOLD  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HPRIME = 64'h00000100000001b3;

  localparam int unsigned ROT_AMT = 27;
  localparam int unsigned XS_AMT  = 33;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SEED,
    S_LDW,
    S_XS,
    S_FOLD,
    S_ADDG,
    S_TAIL,
    S_FIN0,
    S_FIN1,
    S_OUT,
    S_MUL0,
    S_MUL1,
    S_MUL2
  } ctl_state_t;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_SEED,
    DP_LDW,
    DP_XS,
    DP_FOLD,
    DP_ADDG,
    DP_TAIL,
    DP_FIN0,
    DP_OUT
  } dp_op_t;

  // multiplier constant select
  typedef enum logic [1:0] {
    MC_C1,
    MC_C2,
    MC_PRIME
  } mconst_t;

  typedef struct packed {
    dp_op_t  op;
    mconst_t mc;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic full;
  } dp_stat_t;

endpackage

@@ design/bmh64_dpath.sv @@
// ----------------------------------------------------------------------------
// bmh64_dpath
// Hash datapath: seed register, running hash, working operand, a shared
// 32x32 multiplier building a 64-bit low product from the low-by-low term and
// the two cross terms, and the result register.
// ----------------------------------------------------------------------------
module bmh64_dpath
  import bmh64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic [47:0] in_message_length,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic [63:0] out_hash_value
);

  logic [63:0] seed_r;
  logic [63:0] hash_r;
  logic [63:0] opnd_r;
  logic [63:0] acc_r;
  logic [63:0] word_r;
  logic [63:0] out_r;
  dp_stat_t    stat_r;

  logic [63:0] byte_mask;
  logic [63:0] word_masked;
  logic [63:0] mconst;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] prod;
  logic [63:0] acc_xs;
  logic [63:0] hash_xs;
  logic [63:0] fold_in;

  // keep bytes below the count; counts above eight keep all
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_mask[8*i +: 8] = (in_byte_count > 4'(i)) ? 8'hFF : 8'h00;
    end
  end

  assign word_masked = in_data_word & byte_mask;

  always_comb begin
    unique case (cmd.mc)
      MC_C1:    mconst = HC1;
      MC_C2:    mconst = HC2;
      MC_PRIME: mconst = HPRIME;
      default:  mconst = HC1;
    endcase
  end

  // low 64 bits of opnd * const: lo*lo, then the two cross terms into the top half
  assign mul_x = (cmd.op == DP_MUL2) ? opnd_r[63:32] : opnd_r[31:0];
  assign mul_y = (cmd.op == DP_MUL1) ? mconst[63:32] : mconst[31:0];
  assign prod  = 64'(mul_x) * 64'(mul_y);

  assign acc_xs  = acc_r ^ (acc_r >> XS_AMT);
  assign hash_xs = hash_r ^ (hash_r >> XS_AMT);
  assign fold_in = hash_r ^ acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        word_r       <= word_masked;
        opnd_r       <= in_first_word ? {16'b0, in_message_length} : word_masked;
        stat_r.first <= in_first_word;
        stat_r.last  <= in_last_word;
        stat_r.full  <= (in_byte_count >= 4'd8);
      end
      DP_MUL0: acc_r <= prod;
      DP_MUL1, DP_MUL2: acc_r[63:32] <= acc_r[63:32] + prod[31:0];
      DP_SEED: hash_r <= seed_r ^ HGOLD ^ acc_r;
      DP_LDW:  opnd_r <= word_r;
      DP_XS:   opnd_r <= acc_xs;
      DP_FOLD: opnd_r <= {fold_in[63-ROT_AMT:0], fold_in[63:64-ROT_AMT]};
      DP_ADDG: hash_r <= acc_r + HGOLD;
      DP_TAIL: hash_r <= hash_r ^ acc_xs;
      DP_FIN0: opnd_r <= hash_xs;
      DP_OUT:  out_r  <= acc_xs;
      DP_NOP:  ;
      default: ;
    endcase
  end

  assign stat           = stat_r;
  assign out_hash_value = out_r;

endmodule

@@ design/bmh64_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmh64_ctrl
// Sequencer: handshakes, message state and the step order of the datapath,
// including the multiply sequence (S_MUL0, S_MUL1, S_MUL2) with its return state.
// ----------------------------------------------------------------------------
module bmh64_ctrl
  import bmh64_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;
  ctl_state_t ret_r, ret_nxt;
  mconst_t    mc_r, mc_nxt;
  logic       in_msg_r, in_msg_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       in_acc;

  assign out_free = !out_valid_r || out_ready;
  assign in_acc   = in_valid && (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    mc_nxt    = mc_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_DISP;
      S_DISP: begin
        if (stat.first) begin
          state_nxt = S_MUL0;
          mc_nxt    = MC_C1;
          ret_nxt   = S_SEED;
        end else if (!in_msg_r) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MUL0;
          mc_nxt    = MC_C1;
          ret_nxt   = (!stat.last || stat.full) ? S_XS : S_TAIL;
        end
      end
      S_SEED: state_nxt = S_LDW;
      S_LDW: begin
        state_nxt = S_MUL0;
        mc_nxt    = MC_C1;
        ret_nxt   = (!stat.last || stat.full) ? S_XS : S_TAIL;
      end
      S_XS: begin
        state_nxt = S_MUL0;
        mc_nxt    = MC_C2;
        ret_nxt   = S_FOLD;
      end
      S_FOLD: begin
        state_nxt = S_MUL0;
        mc_nxt    = MC_PRIME;
        ret_nxt   = S_ADDG;
      end
      // a full last word leaves a zero tail, which changes nothing
      S_ADDG: state_nxt = stat.last ? S_FIN0 : S_IDLE;
      S_TAIL: state_nxt = S_FIN0;
      S_FIN0: begin
        state_nxt = S_MUL0;
        mc_nxt    = MC_C1;
        ret_nxt   = S_FIN1;
      end
      S_FIN1: begin
        state_nxt = S_MUL0;
        mc_nxt    = MC_C2;
        ret_nxt   = S_OUT;
      end
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = ret_r;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op        = DP_NOP;
    cmd.mc        = mc_r;
    in_msg_nxt    = in_msg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: if (in_acc) cmd.op = DP_LOAD;
      S_DISP: if (stat.first) in_msg_nxt = 1'b1;
      S_SEED: cmd.op = DP_SEED;
      S_LDW:  cmd.op = DP_LDW;
      S_XS:   cmd.op = DP_XS;
      S_FOLD: cmd.op = DP_FOLD;
      S_ADDG: cmd.op = DP_ADDG;
      S_TAIL: cmd.op = DP_TAIL;
      S_FIN0: cmd.op = DP_FIN0;
      S_FIN1: cmd.op = DP_XS;
      S_OUT: begin
        if (out_free) begin
          cmd.op        = DP_OUT;
          in_msg_nxt    = 1'b0;
          out_valid_nxt = 1'b1;
        end
      end
      S_MUL0: cmd.op = DP_MUL0;
      S_MUL1: cmd.op = DP_MUL1;
      S_MUL2: cmd.op = DP_MUL2;
      default: cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      mc_r        <= MC_C1;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      mc_r        <= mc_nxt;
      in_msg_r    <= in_msg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DISP)
    else $error("accepted transaction not dispatched");

  a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL0 |=> state_r == S_MUL1 ##1 state_r == S_MUL2)
    else $error("multiply sequence broken");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && out_free |=> out_valid_r && !in_msg_r && state_r == S_IDLE)
    else $error("result not loaded or message not closed");

  a_seed_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEED) |-> in_msg_r)
    else $error("seeding outside an open message");

endmodule

@@ design/block_mix_hash64.sv @@
// ----------------------------------------------------------------------------
// block_mix_hash64
// Streaming 64-bit block hash with fmix64 finalizer, seed register.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; in_ready is high only while idle.
// All 64-bit multiplies run on a single shared 32x32 multiplier, so that
// unit sets the pace. An ignored word goes straight back to idle. A word
// inside a message is mixed as a full block when it is not the last or is
// a full last word; a partial last word takes the shorter tail path. A
// first word adds seeding, and a last word adds finalization before the
// result is loaded into the output register. The result register lets the
// next transaction start while the hash still waits to be taken; a further
// result waits in its final step until the register is free.
// ----------------------------------------------------------------------------
module block_mix_hash64
  import bmh64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic [47:0] in_message_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_value
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bmh64_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bmh64_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_data_word      (in_data_word),
    .in_byte_count     (in_byte_count),
    .in_first_word     (in_first_word),
    .in_last_word      (in_last_word),
    .in_message_length (in_message_length),
    .cmd               (cmd),
    .stat              (stat),
    .out_hash_value    (out_hash_value)
  );

endmodule

@@ verif/tb_block_mix_hash64.sv @@
// ----------------------------------------------------------------------------
// tb_block_mix_hash64
// Self-checking bench for the streaming 64-bit block mix hash.
// A queue-fed driver offers message words and a clocked monitor takes the
// hashes. Every accepted word goes through a local model of the hash, and
// each hash taken from the block is compared against the oldest prediction.
// The run starts with a directed set of corner words and then moves on to
// random messages. It steps through several seeds and idle/stall mixes, and
// one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_block_mix_hash64
  import bmh64_pkg::*;
();

  typedef struct {
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        first;
    logic        last;
    logic [47:0] len;
  } msg_word_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data_word = '0;
  logic [3:0]  in_byte_count = '0;
  logic        in_first_word = 1'b0;
  logic        in_last_word = 1'b0;
  logic [47:0] in_message_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_hash_value;

  block_mix_hash64 uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_word      (in_data_word),
    .in_byte_count     (in_byte_count),
    .in_first_word     (in_first_word),
    .in_last_word      (in_last_word),
    .in_message_length (in_message_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hash_value    (out_hash_value)
  );

  // model state
  logic [63:0] seed_reg = '0;
  logic [63:0] run_hash = '0;
  bit          msg_open = 1'b0;

  msg_word_t   word_q[$];
  logic [63:0] hash_q[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_start = 1'b0;
  int unsigned hold_left = 0;

  int unsigned err_count = 0;
  int unsigned words_taken = 0;
  int unsigned hashes_checked = 0;
  int unsigned seeds_used = 0;

  msg_word_t   acc_word;
  msg_word_t   nxt_word;
  logic [63:0] acc_hash;
  logic [63:0] want_hash;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: timeout with %0d hashes outstanding", hash_q.size());
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    $display("tb: mismatch %0d: %s got %h want %h", err_count, what, got, want);
  endtask

  // Advance the model by one word; returns 1 when a hash comes out.
  function automatic bit hash_word(input msg_word_t it, output logic [63:0] hv);
    logic [63:0] w;
    logic [63:0] h;
    logic [63:0] k;
    int          cnt;
    bit          res;
    w = it.word;
    cnt = it.cnt;
    res = 1'b0;
    hv = '0;
    if (it.first) begin
      run_hash = seed_reg ^ HGOLD ^ ({16'd0, it.len} * HC1);
      msg_open = 1'b1;
    end
    if (msg_open) begin
      if (cnt > 8) cnt = 8;
      if (cnt < 8) w = w & ((64'd1 << (8 * cnt)) - 64'd1);
      h = run_hash;
      if (!it.last || cnt == 8) begin
        k = w * HC1;
        k = k ^ (k >> XS_AMT);
        k = k * HC2;
        h = h ^ k;
        h = ((h << ROT_AMT) | (h >> (64 - ROT_AMT))) * HPRIME + HGOLD;
        w = '0;
      end
      if (!it.last) begin
        run_hash = h;
      end else begin
        w = w * HC1;
        w = w ^ (w >> XS_AMT);
        h = h ^ w;
        h = h ^ (h >> 33);
        h = h * HC1;
        h = h ^ (h >> 33);
        h = h * HC2;
        h = h ^ (h >> 33);
        hv = h;
        res = 1'b1;
        run_hash = '0;
        msg_open = 1'b0;
      end
    end
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        acc_word.word  = in_data_word;
        acc_word.cnt   = in_byte_count;
        acc_word.first = in_first_word;
        acc_word.last  = in_last_word;
        acc_word.len   = in_message_length;
        if (hash_word(acc_word, acc_hash)) hash_q = {hash_q, acc_hash};
        words_taken++;
      end
      // hold the payload until the transaction is taken
      if (!in_valid || in_ready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt_word = word_q.pop_front();
          in_valid          <= 1'b1;
          in_data_word      <= nxt_word.word;
          in_byte_count     <= nxt_word.cnt;
          in_first_word     <= nxt_word.first;
          in_last_word      <= nxt_word.last;
          in_message_length <= nxt_word.len;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (hash_q.size() == 0) begin
          report_mismatch("hash with none pending", out_hash_value, 'x);
        end else begin
          want_hash = hash_q.pop_front();
          if (out_hash_value !== want_hash)
            report_mismatch("hash_value", out_hash_value, want_hash);
          hashes_checked++;
        end
      end
      out_ready <= !hold_start && hold_left == 0 && $urandom_range(99) >= stall_pct;
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (hold_start) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic push_word(input logic [63:0] word, input logic [3:0] cnt,
                           input logic first, input logic last,
                           input logic [47:0] len);
    msg_word_t it;
    it.word = word;
    it.cnt = cnt;
    it.first = first;
    it.last = last;
    it.len = len;
    word_q = {word_q, it};
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rand48();
    logic [31:0] hi;
    hi = $urandom;
    return {hi[15:0], $urandom};
  endfunction

  // Wait for every word to be taken and every hash to come out, then let
  // the block finish any ignored or unterminated word.
  task automatic drain();
    while (word_q.size() != 0 || in_valid || hash_q.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    seed_reg = value;
    seeds_used++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random_phase(input int n);
    int pushed;
    int r;
    int len;
    int nw;
    int tail;
    logic [47:0] len_field;
    pushed = 0;
    while (pushed < n) begin
      r = $urandom_range(99);
      if (r < 80) begin
        // well-formed message, mostly short
        len = ($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(0, 40);
        nw = (len == 0) ? 1 : (len + 7) / 8;
        tail = (len == 0) ? 0 : ((len % 8 == 0) ? 8 : len % 8);
        len_field = ($urandom_range(9) == 0) ? rand48() : 48'(len);
        for (int i = 0; i < nw; i++) begin
          push_word(rand64(), (i == nw - 1) ? 4'(tail) : 4'd8, i == 0, i == nw - 1,
                    len_field);
          pushed++;
        end
      end else if (r < 88) begin
        // open a message and abandon it, odd counts included
        nw = $urandom_range(1, 4);
        for (int i = 0; i < nw; i++) begin
          push_word(rand64(), 4'($urandom_range(15)), i == 0, 1'b0, rand48());
          pushed++;
        end
      end else if (r < 96) begin
        push_word(rand64(), 4'($urandom_range(15)), 1'($urandom), 1'($urandom), rand48());
        pushed++;
      end else begin
        // stray word, ignored while no message is open
        push_word(rand64(), 4'($urandom_range(15)), 1'b0, 1'($urandom), rand48());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, seed at zero
    write_seed(64'd0);
    push_word(64'hDEAD_BEEF_0123_4567, 4'd8, 1'b0, 1'b1, 48'd8);   // idle, ignored
    push_word('1, 4'd0, 1'b1, 1'b1, 48'd0);                         // empty message
    push_word('1, 4'd8, 1'b1, 1'b1, 48'd8);                         // one full word
    push_word('1, 4'd5, 1'b1, 1'b1, 48'd5);                         // one partial word
    push_word(64'd0, 4'd8, 1'b1, 1'b0, 48'd20);
    push_word('1, 4'd8, 1'b0, 1'b0, 48'd0);
    push_word(rand64(), 4'd4, 1'b0, 1'b1, 48'd0);
    push_word('1, 4'd15, 1'b1, 1'b1, '1);                           // count above eight
    push_word(rand64(), 4'd9, 1'b1, 1'b0, 48'd16);
    push_word(rand64(), 4'd8, 1'b0, 1'b1, 48'd16);
    push_word('1, 4'd3, 1'b1, 1'b0, 48'd10);                        // partial, not last
    push_word('1, 4'd7, 1'b0, 1'b1, 48'd10);
    push_word(rand64(), 4'd8, 1'b1, 1'b0, 48'd64);                  // dropped by restart
    push_word(rand64(), 4'd2, 1'b1, 1'b1, 48'd2);
    push_word(rand64(), 4'd8, 1'b1, 1'b0, 48'd3);                   // length disagrees
    push_word(rand64(), 4'd8, 1'b0, 1'b0, 48'd0);
    push_word(rand64(), 4'd1, 1'b0, 1'b1, 48'd0);
    push_word(rand64(), 4'd0, 1'b1, 1'b0, 48'd1);                   // empty word, not last
    push_word(64'h8000_0000_0000_0001, 4'd8, 1'b0, 1'b1, 48'd0);
    push_word('1, 4'd6, 1'b0, 1'b0, '1);                            // ignored after close
    drain();

    idle_pct = 0;
    stall_pct = 0;
    write_seed(rand64());
    run_random_phase(250);
    drain();

    idle_pct = 56;
    stall_pct = 0;
    write_seed('1);
    run_random_phase(250);
    drain();

    // long hold-off while words keep coming, so the block backs up
    idle_pct = 0;
    stall_pct = 56;
    write_seed(rand64());
    run_random_phase(250);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    drain();

    idle_pct = 35;
    stall_pct = 35;
    write_seed(rand64());
    run_random_phase(250);
    drain();

    if (hash_q.size() != 0)
      report_mismatch("hashes never produced", 64'(hash_q.size()), 64'd0);

    $display("tb: %0d words taken, %0d hashes checked, %0d mismatches", words_taken,
             hashes_checked, err_count);
    $display("tb: %0d seed settings, idle and stall mixes plus one long hold-off",
             seeds_used);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
